// File: src/s256v_pkg.sv
package s256v_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;
    localparam int unsigned NUM_CFG = 4;
    localparam logic [4:0] ADDR_DIG0 = 5'h00;
    localparam logic [4:0] ADDR_DIG1 = 5'h08;
    localparam logic [4:0] ADDR_DIG2 = 5'h10;
    localparam logic [4:0] ADDR_DIG3 = 5'h18;

endpackage

// File: src/sha256_stream_verify.sv
// SHA-256 hasher with digest check.
// Input channel (s_valid/s_ready): one item carries data_byte, byte_present
// and end_of_message. Bytes fill a 64-byte block buffer (sixteen words); a bare
// end marker (byte_present low) closes a message with no byte, so empty
// messages work.
// A byte item is stored and the input stays ready unless the byte fills the block;
// then the block is compressed by one shared round unit, one round per cycle,
// and folded into the hash state, and the input is not ready meanwhile.
// An end item appends 0x80, zero fill and the 64-bit bit length. A tail of up
// to 55 bytes needs one padding block; a tail of 56 or more bytes needs two
// blocks, and an end byte that completes a block is followed by one padding
// block. Then eight items leave on the result channel (m_valid/m_ready),
// word 0 first, one per cycle at best, each flagged with whether the whole
// digest equals the expected digest registers.
// A stall on the result channel holds the current word and the sequencer.
// Configuration: four 64-bit APB registers at 0x00, 0x08, 0x10, 0x18.
// Reset (aresetn low, synchronous) restores the initial hash, clears the
// fill count, bit length, expected digest and the output valid.
module sha256_stream_verify (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_digest_match,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    s256v_pkg::state_t state_reg, state_next;

    logic [63:0] exp_reg [s256v_pkg::NUM_CFG];
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];      // schedule window, w_reg[0] is current word
    logic [31:0] blk_reg [16];    // message block, big-endian bytes per word
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;         // closing message: padding pending or done
    logic        pad2_reg;        // second (length) block still to run
    logic        done_reg;        // length block loaded, digest follows
    logic [2:0]  oidx_reg;
    logic        match_reg;

    assign pready = 1'b1;
    assign s_ready = (state_reg == s256v_pkg::ST_IDLE);

    always_comb begin
        unique case (paddr)
            s256v_pkg::ADDR_DIG0: prdata = exp_reg[0];
            s256v_pkg::ADDR_DIG1: prdata = exp_reg[1];
            s256v_pkg::ADDR_DIG2: prdata = exp_reg[2];
            s256v_pkg::ADDR_DIG3: prdata = exp_reg[3];
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < s256v_pkg::NUM_CFG; i++) exp_reg[i] <= 64'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2:0] == 3'd0) exp_reg[paddr[4:3]] <= pwdata;
        end
    end

    // shared round unit
    logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2, wnew;
    always_comb begin
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
           ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
           ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        big1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
             ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + s256v_pkg::ROUND_K[rnd_reg] + w_reg[0];
        big0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
             ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    logic [31:0] digest_cmp [8];
    logic        all_match;
    always_comb begin
        all_match = 1'b1;
        for (int i = 0; i < 8; i++) begin
            digest_cmp[i] = hash_reg[i] + v_reg[i];
        end
        for (int i = 0; i < 4; i++) begin
            if ({digest_cmp[2*i], digest_cmp[2*i+1]} != exp_reg[i]) all_match = 1'b0;
        end
    end

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            s256v_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_byte_present && fill_reg == 6'd63)
                        state_next = s256v_pkg::ST_ROUND;
                    else if (s_end_of_message)
                        state_next = s256v_pkg::ST_PAD;
                end
            end
            s256v_pkg::ST_PAD:   state_next = s256v_pkg::ST_ROUND;
            s256v_pkg::ST_ROUND: if (rnd_reg == 6'd63) state_next = s256v_pkg::ST_FINAL;
            s256v_pkg::ST_FINAL: begin
                // a full block that came with the end mark, or a padding block without the length, still needs padding
                if (!fin_reg)      state_next = s256v_pkg::ST_IDLE;
                else if (done_reg) state_next = s256v_pkg::ST_OUT;
                else               state_next = s256v_pkg::ST_PAD;
            end
            s256v_pkg::ST_OUT: if (m_ready && oidx_reg == 3'd7) state_next = s256v_pkg::ST_IDLE;
            default: state_next = s256v_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= s256v_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= s256v_pkg::INIT_HASH[i];
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            fin_reg  <= 1'b0;
            pad2_reg <= 1'b0;
            done_reg <= 1'b0;
            oidx_reg <= '0;
        end else begin
            unique case (state_reg)
                s256v_pkg::ST_IDLE: begin
                    rnd_reg <= '0;
                    oidx_reg <= '0;
                    done_reg <= 1'b0;
                    if (s_fire) begin
                        fin_reg <= s_end_of_message;
                        if (s_byte_present) begin
                            blk_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8]
                                <= s_data_byte;
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                        end
                        // load schedule and working vars for a full block
                        for (int i = 0; i < 15; i++) w_reg[i] <= blk_reg[i];
                        w_reg[15] <= {blk_reg[15][31:8], s_data_byte};
                        for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    end
                end
                s256v_pkg::ST_PAD: begin
                    // build padded block from buffer; fill_reg bytes hold data
                    // (or pad already placed when pad2_reg is set)
                    logic [7:0] pb [64];
                    for (int j = 0; j < 64; j++) begin
                        if (pad2_reg)
                            pb[j] = 8'd0;
                        else if (j < fill_reg)
                            pb[j] = blk_reg[j >> 2][8 * (3 - (j & 3)) +: 8];
                        else if (j == fill_reg)
                            pb[j] = s256v_pkg::PAD_BYTE;
                        else
                            pb[j] = 8'd0;
                    end
                    if (pad2_reg || fill_reg < 6'(s256v_pkg::LEN_POS)) begin
                        for (int j = 0; j < 8; j++) pb[63-j] = len_reg[8*j +: 8];
                        pad2_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        pad2_reg <= 1'b1;
                    end
                    for (int i = 0; i < 16; i++)
                        w_reg[i] <= {pb[4*i], pb[4*i+1], pb[4*i+2], pb[4*i+3]};
                    for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    rnd_reg <= '0;
                end
                s256v_pkg::ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 6'd1;
                end
                s256v_pkg::ST_FINAL: begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= digest_cmp[i];
                    match_reg <= all_match;
                end
                s256v_pkg::ST_OUT: begin
                    if (m_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) hash_reg[i] <= s256v_pkg::INIT_HASH[i];
                            fill_reg <= '0;
                            len_reg  <= '0;
                            fin_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = (state_reg == s256v_pkg::ST_OUT);
    assign m_digest_word  = hash_reg[oidx_reg];
    assign m_word_index   = oidx_reg;
    assign m_last_word    = (oidx_reg == 3'd7);
    assign m_digest_match = match_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index));

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid));

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == s256v_pkg::ST_ROUND && rnd_reg == 6'd63
        |=> state_reg == s256v_pkg::ST_FINAL);

    a_last_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> s_ready);

endmodule

// File: verif/sha256_stream_verify_tb.sv
module sha256_stream_verify_tb;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        match;
    } digest_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;
    logic        m_digest_match;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    sha256_stream_verify DUT (.*);

    // Local copy of the hash state and the expected digest registers.
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;
    logic [63:0] golden_digest [4];

    digest_out_t pending_words [$];
    int          mismatch_count;
    int          idle_cycles;
    bit          timed_out;
    bit          hold_off;
    int          hold_cycles;
    bit          rx_throttle;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the round function over msg_block into hash_state.
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s256v_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = s256v_pkg::INIT_HASH[i];
        block_fill = 0;
        msg_bits   = '0;
    endtask

    // Fold one item into the local hash and queue the digest words it causes.
    task automatic predict_item(logic [7:0] b, logic present, logic eom);
        bit match;
        if (present) begin
            msg_block[block_fill] = b;
            block_fill++;
            msg_bits += 64'd8;
            if (block_fill == 64) begin
                sha_compress();
                block_fill = 0;
            end
        end
        if (!eom) return;
        msg_block[block_fill] = s256v_pkg::PAD_BYTE;
        block_fill++;
        if (block_fill > s256v_pkg::LEN_POS) begin
            while (block_fill < 64) msg_block[block_fill++] = 8'h00;
            sha_compress();
            block_fill = 0;
        end
        while (block_fill < s256v_pkg::LEN_POS) msg_block[block_fill++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
        sha_compress();
        match = 1'b1;
        for (int i = 0; i < 4; i++)
            if ({hash_state[2*i], hash_state[2*i+1]} != golden_digest[i]) match = 1'b0;
        for (int i = 0; i < 8; i++)
            pending_words.push_back('{hash_state[i], 3'(i), i == 7, match});
        restart_hash();
    endtask

    // Offer one item after the given gap; hold it until accepted.
    task automatic send_item(logic [7:0] b, logic present, logic eom, int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_byte_present   <= present;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        predict_item(b, present, eom);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic apb_write(int idx, logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 8);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        golden_digest[idx] = val;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop the input, drain all expected words, then allow the block to settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0 && !timed_out) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Send a whole message; a bare end marker closes it when requested.
    task automatic send_message(int len, bit bare_end, bit noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, pick_gap());
            send_item(8'($urandom), 1'b1, !bare_end && i == len - 1, pick_gap());
        end
        if (bare_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1, pick_gap());
    endtask

    // Load the next digest into the registers so that matches occur.
    task automatic arm_match_for(int len);
        logic [7:0]  save_block [64];
        logic [31:0] save_hash [8];
        int unsigned save_fill;
        logic [63:0] save_bits;
        save_block = msg_block; save_hash = hash_state;
        save_fill = block_fill; save_bits = msg_bits;
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h61 + 8'(i % 26);
        block_fill = 0;
        msg_bits = '0;
        for (int i = 0; i < len; i++) begin
            msg_block[block_fill] = 8'h61 + 8'(i % 26);
            block_fill++; msg_bits += 8;
            if (block_fill == 64) begin sha_compress(); block_fill = 0; end
        end
        msg_block[block_fill++] = s256v_pkg::PAD_BYTE;
        if (block_fill > s256v_pkg::LEN_POS) begin
            while (block_fill < 64) msg_block[block_fill++] = 8'h00;
            sha_compress(); block_fill = 0;
        end
        while (block_fill < s256v_pkg::LEN_POS) msg_block[block_fill++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
        sha_compress();
        for (int i = 0; i < 4; i++) apb_write(i, {hash_state[2*i], hash_state[2*i+1]});
        msg_block = save_block; hash_state = save_hash;
        block_fill = save_fill; msg_bits = save_bits;
    endtask

    task automatic send_alpha(int len);
        for (int i = 0; i < len; i++)
            send_item(8'h61 + 8'(i % 26), 1'b1, i == len - 1, pick_gap());
    endtask

    task automatic test_directed_edges();
        send_item(8'h00, 1'b0, 1'b1, 0);          // empty message
        send_item(8'hff, 1'b0, 1'b0, 1);          // empty item, ignored
        send_item(8'hff, 1'b1, 1'b1, 0);          // byte with end mark
        send_item(8'h00, 1'b1, 1'b0, 0);
        send_item(8'h5a, 1'b1, 1'b0, 0);
        send_item(8'ha5, 1'b0, 1'b1, 2);          // bare end after bytes
        send_message(55, 1'b0, 1'b0);             // tail just fits
        wait_idle();
    endtask

    task automatic test_padding_boundaries();
        send_message(56, 1'b0, 1'b0);             // tail needs an extra block
        send_message(64, 1'b1, 1'b0);             // full block then bare end
        wait_idle();
    endtask

    task automatic test_digest_match();
        arm_match_for(3);
        send_alpha(3);
        wait_idle();
        arm_match_for(70);
        send_alpha(70);
        wait_idle();
        for (int i = 0; i < 4; i++) apb_write(i, 64'hffff_ffff_ffff_ffff);
        send_alpha(3);
        wait_idle();
    endtask

    task automatic test_backpressure();
        // Hold the result side off while messages keep coming.
        hold_cycles = 600;
        hold_off    = 1'b1;
        send_message(2, 1'b0, 1'b0);
        send_message(1, 1'b1, 1'b0);
        send_message(0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_stream();
        int sent;
        int len;
        int r;
        sent = 0;
        rx_throttle = 1'b1;
        while (sent < 60 && !timed_out) begin
            r = $urandom_range(0, 9);
            len = (r < 6) ? $urandom_range(0, 8) : (r < 9) ? $urandom_range(50, 70)
                : $urandom_range(100, 130);
            if (len > 64 - sent) len = 64 - sent;
            send_message(len, $urandom_range(0, 3) == 0, 1'b1);
            sent += len + 1;
            if ($urandom_range(0, 4) == 0) begin
                wait_idle();
                for (int i = 0; i < 4; i++) apb_write(i, {$urandom, $urandom});
            end
        end
        wait_idle();
    endtask

    // Result-side readiness: random stalls, or one long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
            if (hold_cycles == 0) hold_off <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else if (!rx_throttle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                       ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1;
        end
    end

    // Compare each accepted digest word against the oldest expected one.
    always @(posedge aclk) begin
        digest_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %h idx %0d", m_digest_word, m_word_index);
            end else begin
                want = pending_words.pop_front();
                if (want != {m_digest_word, m_word_index, m_last_word, m_digest_match}) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.word, want.index, want.last, want.match,
                                 m_digest_word, m_word_index, m_last_word,
                                 m_digest_match);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel and no APB access.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("[sha256_stream_verify] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_data_byte = '0; s_byte_present = 1'b0; s_end_of_message = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatch_count = 0; idle_cycles = 0; timed_out = 1'b0;
        hold_off = 1'b0; hold_cycles = 0; rx_throttle = 1'b0;
        for (int i = 0; i < 4; i++) golden_digest[i] = '0;
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
        restart_hash();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        for (int i = 0; i < 4; i++) apb_write(i, 64'h0);
        test_directed_edges();
        test_padding_boundaries();
        test_digest_match();
        test_backpressure();
        test_random_stream();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("[sha256_stream_verify] OK");
        else
            $display("[sha256_stream_verify] ERROR");
        $finish;
    end
endmodule

// File: files.f
src/s256v_pkg.sv
src/sha256_stream_verify.sv
verif/sha256_stream_verify_tb.sv
